@@ rtl/amd_pkg.sv @@
// Shared types and constants of the accelerometer motion detector.
package amd_pkg;

	localparam int AxisW     = 15;
	localparam int MagW      = 15;
	localparam int SqW       = 30;
	localparam int TimeW     = 32;
	localparam int ThrW      = 15;
	localparam int DurW      = 16;
	localparam int AlphaW    = 16;
	localparam int ByteW     = 8;
	localparam int CfgIdxW   = 3;
	localparam int CfgDataW  = 16;
	localparam int StepW     = 4;

	localparam int RootSteps = 15;
	localparam int MulSteps  = 16;
	localparam int SquareLast = 2;

	localparam int GravityResetMg = 1000;
	localparam logic [ByteW-1:0] ByteMax = 8'd254;

	localparam logic [ThrW-1:0]   MoveThrReset   = 15'd50;
	localparam logic [ThrW-1:0]   StillThrReset  = 15'd20;
	localparam logic [DurW-1:0]   MoveDurReset   = 16'd500;
	localparam logic [DurW-1:0]   StillDurReset  = 16'd3000;
	localparam logic [AlphaW-1:0] GravAlphaReset = 16'd3277;
	localparam logic [AlphaW-1:0] EnrgAlphaReset = 16'd19661;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_MOVE_THR    = 3'd0,
		CFG_STILL_THR   = 3'd1,
		CFG_MOVE_DUR    = 3'd2,
		CFG_STILL_DUR   = 3'd3,
		CFG_GRAV_ALPHA  = 3'd4,
		CFG_ENRG_ALPHA  = 3'd5
	} amd_cfg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SQUARE,
		ST_ROOT,
		ST_PREP,
		ST_MUL,
		ST_UPD,
		ST_DEV,
		ST_DECIDE
	} amd_state_t;

endpackage

@@ rtl/amd_if.sv @@
// Sample and result channel interfaces of the motion detector.
interface amd_sample_if;
	logic                                valid;
	logic                                ready;
	logic signed [amd_pkg::AxisW-1:0]    accel_x;
	logic signed [amd_pkg::AxisW-1:0]    accel_y;
	logic signed [amd_pkg::AxisW-1:0]    accel_z;
	logic        [amd_pkg::TimeW-1:0]    now_ms;

	modport source (output valid, accel_x, accel_y, accel_z, now_ms, input ready);
	modport sink   (input valid, accel_x, accel_y, accel_z, now_ms, output ready);
endinterface

interface amd_result_if;
	logic                              valid;
	logic                              ready;
	logic [amd_pkg::ByteW-1:0]         energy_byte;
	logic [amd_pkg::MagW-1:0]          energy_mg;
	logic                              moving;

	modport source (output valid, energy_byte, energy_mg, moving, input ready);
	modport sink   (input valid, energy_byte, energy_mg, moving, output ready);
endinterface

@@ rtl/accel_motion_detector_unit.sv @@
// Accelerometer motion detector: magnitude, gravity and energy averages, hysteresis flag.
//
// Usage:
//  - sample channel: one beat carries accel_x/y/z (milli-g) and now_ms.
//  - result channel: one beat per sample with energy_byte, energy_mg, moving.
//  - configuration: cfg_we/cfg_index/cfg_data write one register per cycle,
//    only while the block is idle; indexes beyond the list are dropped.
//  - A sample goes from accept to result beat through the shared squarer,
//    the bit-pair square root, then for each of the two averages a prep
//    step, the shift-add multiplier and an update step, with the deviation
//    step between the two averages and the decision step last.
//    One serial multiplier serves both averages, so no new sample is taken
//    before the last one is through; sample.ready is high only when idle.
//  - The result sits in an output register; when the receiver stalls the
//    next sample is still accepted and processed, and its decision step
//    holds until the waiting beat is taken.
//  - Reset (arst_n low) restores register defaults, gravity at 1000 mg,
//    zero energy, both timers unset and the flag still.
module accel_motion_detector_unit #(
	parameter int FRAC_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	amd_sample_if.sink                     sample,
	amd_result_if.source                   result,
	input  logic                           cfg_we,
	input  logic [amd_pkg::CfgIdxW-1:0]    cfg_index,
	input  logic [amd_pkg::CfgDataW-1:0]   cfg_data
);

	localparam int AvgW = amd_pkg::MagW + FRAC_BITS;
	localparam logic [AvgW-1:0] GravReset = AvgW'(amd_pkg::GravityResetMg) << FRAC_BITS;

	// configuration registers
	logic [amd_pkg::ThrW-1:0]   move_thr_q, still_thr_q;
	logic [amd_pkg::DurW-1:0]   move_dur_q, still_dur_q;
	logic [amd_pkg::AlphaW-1:0] grav_alpha_q, enrg_alpha_q;

	// architectural state
	logic [AvgW-1:0]            grav_q, enrg_q;
	logic [amd_pkg::TimeW-1:0]  above_q, below_q;
	logic                       moving_q;

	// working registers
	amd_pkg::amd_state_t        state_q, state_d;
	logic [amd_pkg::StepW-1:0]  cnt_q;
	logic [amd_pkg::AxisW-1:0]  axis_q [3];
	logic [amd_pkg::TimeW-1:0]  now_q;
	logic [amd_pkg::SqW-1:0]    rem_q, root_q;
	logic [AvgW-1:0]            dev_q, diff_q, acc_q;
	logic [amd_pkg::AlphaW-1:0] mplier_q;
	logic                       up_q, pass_q;

	// output register
	logic                       res_valid_q;
	logic [amd_pkg::ByteW-1:0]  res_byte_q;
	logic [amd_pkg::MagW-1:0]   res_mg_q;
	logic                       res_moving_q;

	logic                       accept, load_out;

	assign sample.ready = (state_q == amd_pkg::ST_IDLE);
	assign accept       = sample.valid && sample.ready;
	assign load_out     = (state_q == amd_pkg::ST_DECIDE) && (!res_valid_q || result.ready);

	assign result.valid       = res_valid_q;
	assign result.energy_byte = res_byte_q;
	assign result.energy_mg   = res_mg_q;
	assign result.moving      = res_moving_q;

	function automatic logic [amd_pkg::AxisW-1:0] axis_abs(logic [amd_pkg::AxisW-1:0] a);
		return a[amd_pkg::AxisW-1] ? (~a + 1'b1) : a;
	endfunction

	// shared squarer
	logic [amd_pkg::AxisW-1:0] sq_op;
	logic [amd_pkg::SqW-1:0]   sq_prod, sq_sum;
	assign sq_op   = axis_q[cnt_q[1:0]];
	assign sq_prod = amd_pkg::SqW'(sq_op) * amd_pkg::SqW'(sq_op);
	assign sq_sum  = rem_q + sq_prod;

	// square root step: one bit pair per cycle
	logic [amd_pkg::SqW-1:0] rt_bit, rt_trial;
	logic                    rt_fit;
	assign rt_bit   = amd_pkg::SqW'(1) << {cnt_q, 1'b0};
	assign rt_trial = root_q + rt_bit;
	assign rt_fit   = rem_q >= rt_trial;

	// averaging operands
	logic [AvgW-1:0]            mag_fx, target, avg_sel, avg_new;
	logic [amd_pkg::AlphaW-1:0] alpha_sel;
	logic [AvgW:0]              mul_sum;
	assign mag_fx    = AvgW'(root_q[amd_pkg::MagW-1:0]) << FRAC_BITS;
	assign target    = pass_q ? dev_q : mag_fx;
	assign avg_sel   = pass_q ? enrg_q : grav_q;
	assign alpha_sel = pass_q ? enrg_alpha_q : grav_alpha_q;
	assign mul_sum   = {1'b0, acc_q} + (mplier_q[0] ? {1'b0, diff_q} : '0);
	assign avg_new   = up_q ? (avg_sel + acc_q) : (avg_sel - acc_q);

	// decision
	logic                       is_high, is_low;
	logic [amd_pkg::TimeW-1:0]  up_elapsed, dn_elapsed;
	logic [amd_pkg::MagW-1:0]   whole;
	logic [amd_pkg::MagW-3:0]   quarter;
	assign is_high    = enrg_q >= (AvgW'(move_thr_q) << FRAC_BITS);
	assign is_low     = enrg_q <  (AvgW'(still_thr_q) << FRAC_BITS);
	assign up_elapsed = now_q - above_q;
	assign dn_elapsed = now_q - below_q;
	assign whole      = enrg_q[AvgW-1:FRAC_BITS];
	assign quarter    = whole[amd_pkg::MagW-1:2];

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= amd_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			amd_pkg::ST_IDLE: begin
				if (accept) state_d = amd_pkg::ST_SQUARE;
			end
			amd_pkg::ST_SQUARE: begin
				if (cnt_q == amd_pkg::StepW'(amd_pkg::SquareLast)) state_d = amd_pkg::ST_ROOT;
			end
			amd_pkg::ST_ROOT: begin
				if (cnt_q == '0) state_d = amd_pkg::ST_PREP;
			end
			amd_pkg::ST_PREP: begin
				state_d = amd_pkg::ST_MUL;
			end
			amd_pkg::ST_MUL: begin
				if (cnt_q == '0) state_d = amd_pkg::ST_UPD;
			end
			amd_pkg::ST_UPD: begin
				state_d = pass_q ? amd_pkg::ST_DECIDE : amd_pkg::ST_DEV;
			end
			amd_pkg::ST_DEV: begin
				state_d = amd_pkg::ST_PREP;
			end
			amd_pkg::ST_DECIDE: begin
				if (load_out) state_d = amd_pkg::ST_IDLE;
			end
			default: state_d = amd_pkg::ST_IDLE;
		endcase
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			move_thr_q   <= amd_pkg::MoveThrReset;
			still_thr_q  <= amd_pkg::StillThrReset;
			move_dur_q   <= amd_pkg::MoveDurReset;
			still_dur_q  <= amd_pkg::StillDurReset;
			grav_alpha_q <= amd_pkg::GravAlphaReset;
			enrg_alpha_q <= amd_pkg::EnrgAlphaReset;
		end else if (cfg_we) begin
			case (amd_pkg::amd_cfg_idx_t'(cfg_index))
				amd_pkg::CFG_MOVE_THR:   move_thr_q   <= cfg_data[amd_pkg::ThrW-1:0];
				amd_pkg::CFG_STILL_THR:  still_thr_q  <= cfg_data[amd_pkg::ThrW-1:0];
				amd_pkg::CFG_MOVE_DUR:   move_dur_q   <= cfg_data;
				amd_pkg::CFG_STILL_DUR:  still_dur_q  <= cfg_data;
				amd_pkg::CFG_GRAV_ALPHA: grav_alpha_q <= cfg_data;
				amd_pkg::CFG_ENRG_ALPHA: enrg_alpha_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// averages, timers and flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grav_q   <= GravReset;
			enrg_q   <= '0;
			above_q  <= '0;
			below_q  <= '0;
			moving_q <= 1'b0;
		end else begin
			if (state_q == amd_pkg::ST_UPD) begin
				if (pass_q) enrg_q <= avg_new;
				else        grav_q <= avg_new;
			end
			if (load_out) begin
				if (is_high) begin
					below_q <= '0;
					if (above_q == '0) begin
						above_q <= now_q;
					end else if (!moving_q && up_elapsed >= amd_pkg::TimeW'(move_dur_q)) begin
						moving_q <= 1'b1;
					end
				end else if (is_low) begin
					above_q <= '0;
					if (below_q == '0) begin
						below_q <= now_q;
					end else if (moving_q && dn_elapsed >= amd_pkg::TimeW'(still_dur_q)) begin
						moving_q <= 1'b0;
					end
				end else begin
					above_q <= '0;
					below_q <= '0;
				end
			end
		end
	end

	// working datapath: squarer, root, serial multiplier
	always_ff @(posedge clk) begin
		case (state_q)
			amd_pkg::ST_IDLE: begin
				if (accept) begin
					axis_q[0] <= axis_abs(sample.accel_x);
					axis_q[1] <= axis_abs(sample.accel_y);
					axis_q[2] <= axis_abs(sample.accel_z);
					now_q     <= sample.now_ms;
					rem_q     <= '0;
					cnt_q     <= '0;
					pass_q    <= 1'b0;
				end
			end
			amd_pkg::ST_SQUARE: begin
				rem_q <= sq_sum;
				if (cnt_q == amd_pkg::StepW'(amd_pkg::SquareLast)) begin
					root_q <= '0;
					cnt_q  <= amd_pkg::StepW'(amd_pkg::RootSteps - 1);
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
			amd_pkg::ST_ROOT: begin
				if (rt_fit) begin
					rem_q  <= rem_q - rt_trial;
					root_q <= (root_q >> 1) + rt_bit;
				end else begin
					root_q <= root_q >> 1;
				end
				cnt_q <= cnt_q - 1'b1;
			end
			amd_pkg::ST_PREP: begin
				up_q     <= target >= avg_sel;
				diff_q   <= (target >= avg_sel) ? (target - avg_sel) : (avg_sel - target);
				mplier_q <= alpha_sel;
				acc_q    <= '0;
				cnt_q    <= amd_pkg::StepW'(amd_pkg::MulSteps - 1);
			end
			amd_pkg::ST_MUL: begin
				// floor division by two each step keeps the exact floor of the product
				acc_q    <= mul_sum[AvgW:1];
				mplier_q <= mplier_q >> 1;
				cnt_q    <= cnt_q - 1'b1;
			end
			amd_pkg::ST_DEV: begin
				dev_q  <= (mag_fx >= grav_q) ? (mag_fx - grav_q) : (grav_q - mag_fx);
				pass_q <= 1'b1;
			end
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (load_out) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			res_byte_q <= (quarter >= (amd_pkg::MagW-2)'(amd_pkg::ByteMax))
				? amd_pkg::ByteMax : quarter[amd_pkg::ByteW-1:0];
			res_mg_q   <= whole;
			// flag after this sample, same rules as the state update
			if (is_high) begin
				res_moving_q <= moving_q || ((above_q != '0)
					&& (up_elapsed >= amd_pkg::TimeW'(move_dur_q)));
			end else if (is_low) begin
				res_moving_q <= moving_q && !((below_q != '0)
					&& (dn_elapsed >= amd_pkg::TimeW'(still_dur_q)));
			end else begin
				res_moving_q <= moving_q;
			end
		end
	end

endmodule

@@ rtl/amd_checker.sv @@
// Port-level checks of the motion detector, bound to the top level.
module amd_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_valid,
	input logic                          s_ready,
	input logic                          r_valid,
	input logic                          r_ready,
	input logic [amd_pkg::ByteW-1:0]     r_byte,
	input logic [amd_pkg::MagW-1:0]      r_mg,
	input logic                          r_moving
);

	// busy after a sample beat
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_valid && s_ready) |=> !s_ready)
		else $error("sample ready right after a sample beat");

	// a stalled result beat holds
	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(r_valid && !r_ready) |=> (r_valid && $stable(r_byte) && $stable(r_mg)
			&& $stable(r_moving)))
		else $error("stalled result beat changed");

	// energy byte is the saturated quarter of the milli-g value
	a_byte_matches: assert property (@(posedge clk) disable iff (!arst_n)
		r_valid |-> ((r_mg[amd_pkg::MagW-1:2] >= (amd_pkg::MagW-2)'(amd_pkg::ByteMax))
			? (r_byte == amd_pkg::ByteMax)
			: (r_byte == r_mg[amd_pkg::ByteW+1:2])))
		else $error("energy byte disagrees with energy milli-g");

endmodule

bind accel_motion_detector_unit amd_checker u_amd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_valid  (sample.valid),
	.s_ready  (sample.ready),
	.r_valid  (result.valid),
	.r_ready  (result.ready),
	.r_byte   (result.energy_byte),
	.r_mg     (result.energy_mg),
	.r_moving (result.moving)
);

@@ tb/sv/tb_accel_motion_detector_unit.sv @@
// Self-checking testbench for the accelerometer motion detector unit.
module tb_accel_motion_detector_unit;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FracBits     = 16;
	localparam int ResetCycles  = 6;
	localparam int MaxWait      = 18;     // longest gap or stall drawn per beat
	localparam int RandomItems  = 1400;
	localparam int PauseCycles  = 4;      // breathing room before register writes
	localparam int TailCycles   = 64;     // a little over one sample's latency
	localparam int StallLimit   = 4000;   // cycles with no beat on either channel

	// Axis extremes: most negative and most positive 15-bit patterns.
	localparam logic [amd_pkg::AxisW-1:0] AxisMin = 15'h4000;
	localparam logic [amd_pkg::AxisW-1:0] AxisMax = 15'h3FFF;

	// Indexes past the register list; the block must drop these writes.
	localparam logic [amd_pkg::CfgIdxW-1:0] SpareIdxLo = 3'd6;
	localparam logic [amd_pkg::CfgIdxW-1:0] SpareIdxHi = 3'd7;

	typedef struct packed {
		logic [amd_pkg::ByteW-1:0] energy_byte;
		logic [amd_pkg::MagW-1:0]  energy_mg;
		logic                      moving;
	} motion_report_t;

	logic clk = 1'b0;
	logic arst_n;
	logic                          cfg_we;
	logic [amd_pkg::CfgIdxW-1:0]   cfg_index;
	logic [amd_pkg::CfgDataW-1:0]  cfg_data;

	amd_sample_if sample_ch();
	amd_result_if result_ch();

	accel_motion_detector_unit #(
		.FRAC_BITS(FracBits)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample    (sample_ch),
		.result    (result_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Mirror of the register file, as the block should hold it.
	logic [amd_pkg::ThrW-1:0]   move_thr_mg;
	logic [amd_pkg::ThrW-1:0]   still_thr_mg;
	logic [amd_pkg::DurW-1:0]   move_hold_ms;
	logic [amd_pkg::DurW-1:0]   still_hold_ms;
	logic [amd_pkg::AlphaW-1:0] grav_alpha;
	logic [amd_pkg::AlphaW-1:0] enrg_alpha;

	// Detector state: both averages in fixed point, the two arm stamps
	// (zero means unarmed) and the motion flag.
	logic [63:0]                grav_avg;
	logic [63:0]                enrg_avg;
	logic [amd_pkg::TimeW-1:0]  high_since;
	logic [amd_pkg::TimeW-1:0]  low_since;
	logic                       moving_now;

	// Reports still owed by the block, oldest first.
	motion_report_t pending_reports[$];

	int          errors = 0;
	int unsigned accepted_items = 0;
	bit          calm = 1'b0;        // when set, neither side inserts gaps or stalls
	logic [amd_pkg::TimeW-1:0] wall_ms = 32'd1;
	int          pose_x, pose_y, pose_z;

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	// Magnitude of a 15-bit two's complement axis; -16384 maps to 16384.
	function automatic logic [63:0] axis_abs(logic [amd_pkg::AxisW-1:0] raw);
		return raw[amd_pkg::AxisW-1] ? 64'(16'h8000 - {1'b0, raw}) : 64'(raw);
	endfunction

	// Floored square root, two bits of the radicand per pass.
	function automatic logic [63:0] floor_sqrt(logic [63:0] n);
		logic [63:0] root;
		logic [63:0] probe;
		root  = '0;
		probe = 64'd1 << 62;
		while (probe > n)
			probe >>= 2;
		while (probe != 0) begin
			if (n >= root + probe) begin
				n    = n - (root + probe);
				root = (root >> 1) + probe;
			end else begin
				root >>= 1;
			end
			probe >>= 2;
		end
		return root;
	endfunction

	// One step of an exponential average; the step is truncated toward zero.
	function automatic logic [63:0] ease_toward(logic [63:0] avg, logic [63:0] target,
			logic [amd_pkg::AlphaW-1:0] alpha);
		if (target >= avg)
			return avg + ((64'(alpha) * (target - avg)) >> 16);
		return avg - ((64'(alpha) * (avg - target)) >> 16);
	endfunction

	// Advance the detector by one sample and return the report it owes.
	function automatic motion_report_t predict_report(logic [amd_pkg::AxisW-1:0] x,
			logic [amd_pkg::AxisW-1:0] y, logic [amd_pkg::AxisW-1:0] z,
			logic [amd_pkg::TimeW-1:0] stamp);
		logic [63:0]               mag;
		logic [63:0]               dev;
		logic [63:0]               whole;
		logic [amd_pkg::TimeW-1:0] span;
		motion_report_t            rep;
		mag = floor_sqrt(axis_abs(x) * axis_abs(x) + axis_abs(y) * axis_abs(y)
			+ axis_abs(z) * axis_abs(z)) << FracBits;
		// Gravity first; the deviation is taken against the updated gravity.
		grav_avg = ease_toward(grav_avg, mag, grav_alpha);
		dev      = (mag >= grav_avg) ? mag - grav_avg : grav_avg - mag;
		enrg_avg = ease_toward(enrg_avg, dev, enrg_alpha);
		// The high test comes first, so it wins when the thresholds cross.
		if (enrg_avg >= (64'(move_thr_mg) << FracBits)) begin
			low_since = '0;
			span      = stamp - high_since;
			if (high_since == '0)
				high_since = stamp;
			else if (!moving_now && span >= move_hold_ms)
				moving_now = 1'b1;
		end else if (enrg_avg < (64'(still_thr_mg) << FracBits)) begin
			high_since = '0;
			span       = stamp - low_since;
			if (low_since == '0)
				low_since = stamp;
			else if (moving_now && span >= still_hold_ms)
				moving_now = 1'b0;
		end else begin
			high_since = '0;
			low_since  = '0;
		end
		whole           = enrg_avg >> FracBits;
		rep.energy_byte = ((whole >> 2) >= 64'(amd_pkg::ByteMax)) ? amd_pkg::ByteMax
			: amd_pkg::ByteW'(whole >> 2);
		rep.energy_mg   = whole[amd_pkg::MagW-1:0];
		rep.moving      = moving_now;
		return rep;
	endfunction

	function automatic void mirror_reg(logic [amd_pkg::CfgIdxW-1:0] idx,
			logic [amd_pkg::CfgDataW-1:0] data);
		case (idx)
			amd_pkg::CFG_MOVE_THR:   move_thr_mg   = data[amd_pkg::ThrW-1:0];
			amd_pkg::CFG_STILL_THR:  still_thr_mg  = data[amd_pkg::ThrW-1:0];
			amd_pkg::CFG_MOVE_DUR:   move_hold_ms  = data[amd_pkg::DurW-1:0];
			amd_pkg::CFG_STILL_DUR:  still_hold_ms = data[amd_pkg::DurW-1:0];
			amd_pkg::CFG_GRAV_ALPHA: grav_alpha    = data[amd_pkg::AlphaW-1:0];
			amd_pkg::CFG_ENRG_ALPHA: enrg_alpha    = data[amd_pkg::AlphaW-1:0];
			default: ;
		endcase
	endfunction

	// Center plus a uniform offset in [-spread, spread], wrapped to the axis width.
	function automatic logic [amd_pkg::AxisW-1:0] jitter(int center, int spread);
		return amd_pkg::AxisW'(center + int'($urandom_range(0, 2 * spread)) - spread);
	endfunction

	// ------------------------------------------------------------------
	// Drivers
	// ------------------------------------------------------------------

	// Write one register; only called while the block is idle.
	task automatic write_reg(input logic [amd_pkg::CfgIdxW-1:0] idx,
			input logic [amd_pkg::CfgDataW-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		mirror_reg(idx, data);
	endtask

	// Offer one sample beat after a random gap, hold it until taken, then
	// queue the report it should produce. Valid stays high on exit so a
	// back-to-back beat never lowers and raises it in one step.
	task automatic send_sample(input logic [amd_pkg::AxisW-1:0] x,
			input logic [amd_pkg::AxisW-1:0] y, input logic [amd_pkg::AxisW-1:0] z,
			input logic [amd_pkg::TimeW-1:0] stamp);
		int unsigned gap;
		gap = calm ? 0 : $urandom_range(0, MaxWait);
		if (gap != 0) begin
			sample_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_ch.valid   <= 1'b1;
		sample_ch.accel_x <= x;
		sample_ch.accel_y <= y;
		sample_ch.accel_z <= z;
		sample_ch.now_ms  <= stamp;
		@(posedge clk);
		while (sample_ch.ready !== 1'b1)
			@(posedge clk);
		pending_reports.push_back(predict_report(x, y, z, stamp));
		accepted_items++;
	endtask

	// Sample around the current pose; small spread is rest, large is shaking.
	task automatic send_pose(input int spread, input int unsigned step_hi);
		wall_ms = wall_ms + $urandom_range(1, step_hi);
		send_sample(jitter(pose_x, spread), jitter(pose_y, spread), jitter(pose_z, spread),
			wall_ms);
	endtask

	// Drop valid and wait until every owed report has been taken.
	task automatic drain();
		sample_ch.valid <= 1'b0;
		while (pending_reports.size() != 0)
			@(posedge clk);
		repeat (PauseCycles) @(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Reset register values, axis extremes and odd timestamps.
	task automatic test_axis_extremes();
		send_sample(AxisMin, AxisMin, AxisMin, 32'd1);
		send_sample(AxisMax, AxisMax, AxisMax, 32'd2);
		send_sample('0, '0, '0, 32'd3);
		send_sample(15'sd16000, -15'sd16000, 15'sd16000, 32'hFFFF_FFFF);
		send_sample(-15'sd1, 15'sd1, -15'sd1, 32'h8000_0000);
		send_sample('0, '0, 15'sd1000, 32'd0);
		send_sample(AxisMin, '0, '0, 32'h7FFF_FFFF);
	endtask

	// Sustain timers: zero stamp leaves a timer unarmed, exact sustain
	// boundary, band clears both timers, zero still time, wrapping counter.
	task automatic test_timer_edges();
		drain();
		write_reg(amd_pkg::CFG_GRAV_ALPHA, 16'hFFFF);
		write_reg(amd_pkg::CFG_ENRG_ALPHA, 16'hFFFF);
		write_reg(amd_pkg::CFG_MOVE_DUR, 16'd200);
		write_reg(amd_pkg::CFG_STILL_DUR, 16'd0);
		// pull gravity to about 1000 mg, then freeze it (zero alpha)
		send_sample('0, '0, 15'sd1000, 32'd5);
		drain();
		write_reg(amd_pkg::CFG_GRAV_ALPHA, 16'd0);
		send_sample('0, '0, 15'sd2000, 32'd0);
		send_sample('0, '0, 15'sd2000, 32'd50);
		send_sample('0, '0, 15'sd2000, 32'd150);
		send_sample('0, '0, 15'sd2000, 32'd250);
		send_sample('0, '0, 15'sd1030, 32'd260);
		send_sample('0, '0, 15'sd1000, 32'd270);
		send_sample('0, '0, 15'sd1000, 32'd270);
		drain();
		write_reg(amd_pkg::CFG_MOVE_DUR, 16'd100);
		send_sample('0, '0, 15'sd2000, 32'hFFFF_FFC0);
		send_sample('0, '0, 15'sd2000, 32'h0000_0030);
	endtask

	// Masked over-range data, dropped indexes, frozen energy, crossed thresholds.
	task automatic test_register_limits();
		drain();
		write_reg(amd_pkg::CFG_MOVE_THR, 16'hFFFF);
		write_reg(amd_pkg::CFG_STILL_THR, 16'hFFFF);
		write_reg(SpareIdxLo, 16'h0000);
		write_reg(SpareIdxHi, 16'hFFFF);
		write_reg(amd_pkg::CFG_ENRG_ALPHA, 16'd0);
		send_sample('0, '0, 15'sd3000, 32'd400);
		send_sample('0, '0, 15'sd1000, 32'd500);
		drain();
		write_reg(amd_pkg::CFG_MOVE_THR, 16'd10);
		write_reg(amd_pkg::CFG_STILL_THR, 16'd100);
		write_reg(amd_pkg::CFG_ENRG_ALPHA, 16'hFFFF);
		write_reg(amd_pkg::CFG_MOVE_DUR, 16'd0);
		write_reg(amd_pkg::CFG_STILL_DUR, 16'hFFFF);
		send_sample('0, '0, 15'sd1030, 32'd600);
		send_sample('0, '0, 15'sd1030, 32'd700);
		send_sample('0, '0, 15'sd1000, 32'd800);
	endtask

	// New register set: mostly practical values, sometimes all-low or all-high.
	task automatic shuffle_settings();
		logic [amd_pkg::CfgDataW-1:0] mthr, sthr, mdur, sdur, galpha, ealpha;
		case ($urandom_range(0, 7))
			0: begin
				mthr = '0; sthr = '0; mdur = '0; sdur = '0;
				galpha = 16'd1; ealpha = 16'd1;
			end
			1: begin
				mthr = '1; sthr = '1; mdur = '1; sdur = '1;
				galpha = '1; ealpha = '1;
			end
			default: begin
				mthr = amd_pkg::CfgDataW'($urandom_range(20, 300));
				// occasionally cross the thresholds
				sthr = ($urandom_range(0, 5) == 0)
					? amd_pkg::CfgDataW'($urandom_range(mthr, mthr + 100))
					: amd_pkg::CfgDataW'($urandom_range(1, mthr));
				mdur   = amd_pkg::CfgDataW'($urandom_range(0, 1500));
				sdur   = amd_pkg::CfgDataW'($urandom_range(0, 5000));
				galpha = amd_pkg::CfgDataW'($urandom_range(500, 20000));
				ealpha = amd_pkg::CfgDataW'($urandom_range(3000, 65535));
			end
		endcase
		write_reg(amd_pkg::CFG_MOVE_THR, mthr);
		write_reg(amd_pkg::CFG_STILL_THR, sthr);
		write_reg(amd_pkg::CFG_MOVE_DUR, mdur);
		write_reg(amd_pkg::CFG_STILL_DUR, sdur);
		write_reg(amd_pkg::CFG_GRAV_ALPHA, galpha);
		write_reg(amd_pkg::CFG_ENRG_ALPHA, ealpha);
	endtask

	// Episodes of rest followed by shaking, with some raw noise and some
	// runs of broken timestamps; registers change every few episodes.
	task automatic test_random_traffic();
		int unsigned               goal;
		int unsigned               episode;
		int unsigned               kind;
		int unsigned               run;
		int                        spread;
		logic [amd_pkg::TimeW-1:0] stamp;
		goal    = accepted_items + RandomItems;
		episode = 0;
		while (accepted_items < goal) begin
			if (episode % 6 == 0) begin
				drain();
				shuffle_settings();
			end
			calm = ($urandom_range(0, 4) == 0);
			case ($urandom_range(0, 3))
				0: begin pose_x = 0;    pose_y = 0;     pose_z = 1000; end
				1: begin pose_x = 1000; pose_y = 0;     pose_z = 0;    end
				2: begin pose_x = 0;    pose_y = -1000; pose_z = 0;    end
				default: begin pose_x = 577; pose_y = 577; pose_z = 577; end
			endcase
			// park the millisecond counter just short of its wrap now and then
			if ($urandom_range(0, 9) == 0)
				wall_ms = 32'hFFFF_FFFF - $urandom_range(0, 3000);
			kind = $urandom_range(0, 19);
			if (kind < 14) begin
				run = $urandom_range(5, 40);
				repeat (run) send_pose(3, 140);
				// either a mild wobble into the band or a real shake
				spread = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
					: $urandom_range(100, 15000);
				run = $urandom_range(3, 25);
				repeat (run) send_pose(spread, 140);
			end else if (kind < 17) begin
				run = $urandom_range(3, 12);
				repeat (run)
					send_sample(amd_pkg::AxisW'($urandom), amd_pkg::AxisW'($urandom),
						amd_pkg::AxisW'($urandom), $urandom);
			end else begin
				run    = $urandom_range(3, 12);
				spread = $urandom_range(0, 3000);
				repeat (run) begin
					case ($urandom_range(0, 3))
						0: stamp = '0;
						1: stamp = wall_ms - $urandom_range(1, 5000);
						2: stamp = $urandom;
						default: stamp = wall_ms;
					endcase
					send_sample(jitter(pose_x, spread), jitter(pose_y, spread),
						jitter(pose_z, spread), stamp);
				end
			end
			episode++;
		end
		calm = 1'b0;
	endtask

	// ------------------------------------------------------------------
	// Result side: random stalls and the report check
	// ------------------------------------------------------------------

	function automatic void note_mismatch(string field, int want, int got);
		errors++;
		$display("%0t ns: %s expected %0d, actual %0d", $time, field, want, got);
	endfunction

	initial begin : report_side
		int unsigned    hold;
		motion_report_t want;
		hold = 0;
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n === 1'b1 && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
				if (pending_reports.size() == 0) begin
					errors++;
					$display("%0t ns: report beat with nothing owed: byte %0d mg %0d moving %0b",
						$time, result_ch.energy_byte, result_ch.energy_mg, result_ch.moving);
				end else begin
					want = pending_reports.pop_front();
					if (result_ch.energy_byte !== want.energy_byte)
						note_mismatch("energy_byte", want.energy_byte, result_ch.energy_byte);
					if (result_ch.energy_mg !== want.energy_mg)
						note_mismatch("energy_mg", want.energy_mg, result_ch.energy_mg);
					if (result_ch.moving !== want.moving)
						note_mismatch("moving", want.moving, result_ch.moving);
				end
				// draw the stall to apply after this beat
				hold = calm ? 0 : $urandom_range(0, MaxWait);
			end
			if (hold != 0) begin
				hold--;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= 1'b1;
			end
		end
	end

	// Stall watchdog: end the run if neither channel moves for too long.
	initial begin : stall_watch
		int unsigned quiet;
		quiet = 0;
		while (quiet < StallLimit) begin
			@(posedge clk);
			if ((sample_ch.valid === 1'b1 && sample_ch.ready === 1'b1)
					|| (result_ch.valid === 1'b1 && result_ch.ready === 1'b1))
				quiet = 0;
			else
				quiet++;
		end
		$display("Test completed with failures");
		$finish;
	end

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------

	initial begin : run_tests
		arst_n            <= 1'b0;
		cfg_we            <= 1'b0;
		cfg_index         <= amd_pkg::CFG_MOVE_THR;
		cfg_data          <= '0;
		sample_ch.valid   <= 1'b0;
		sample_ch.accel_x <= '0;
		sample_ch.accel_y <= '0;
		sample_ch.accel_z <= '0;
		sample_ch.now_ms  <= '0;

		// register defaults and detector state after reset
		move_thr_mg   = amd_pkg::MoveThrReset;
		still_thr_mg  = amd_pkg::StillThrReset;
		move_hold_ms  = amd_pkg::MoveDurReset;
		still_hold_ms = amd_pkg::StillDurReset;
		grav_alpha    = amd_pkg::GravAlphaReset;
		enrg_alpha    = amd_pkg::EnrgAlphaReset;
		grav_avg      = 64'(amd_pkg::GravityResetMg) << FracBits;
		enrg_avg      = '0;
		high_since    = '0;
		low_since     = '0;
		moving_now    = 1'b0;

		repeat (ResetCycles) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_axis_extremes();
		test_timer_edges();
		test_register_limits();
		test_random_traffic();

		// hold until every report is in, then let the pipeline settle
		drain();
		repeat (TailCycles) @(posedge clk);
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/amd_pkg.sv
rtl/amd_if.sv
rtl/accel_motion_detector_unit.sv
rtl/amd_checker.sv
tb/sv/tb_accel_motion_detector_unit.sv
